FILE: rtl/pcs_frm_pkg.sv
// Shared types, block codes and constants for the 64b/66b frame encoder.
// No dependencies; imported by every module of the encoder.
package pcs_frm_pkg;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int BLOCK_W    = 64;
    localparam int SYNC_W     = 2;
    localparam int SCR_W      = 58;
    localparam int HELD_W     = 3;
    localparam int IDLE_CNT_W = 6;   // up to 31 full idles plus one extra
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 58;

    // Sync headers
    localparam logic [SYNC_W-1:0] SYNC_CTRL = 2'd1;
    localparam logic [SYNC_W-1:0] SYNC_DATA = 2'd2;

    // Control block type codes
    localparam logic [7:0] TYPE_IDLE        = 8'h1e;
    localparam logic [7:0] TYPE_START_SHORT = 8'h33;
    localparam logic [7:0] TYPE_START_LONG  = 8'h78;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_SEED  = 2'd1;

    // Reset values and limits
    localparam logic [7:0]       GAP_MIN    = 8'd12;
    localparam logic [7:0]       GAP_RESET  = 8'd12;
    localparam logic [SCR_W-1:0] SEED_RESET = {SCR_W{1'b1}};

    localparam int QUEUE_DEPTH_DEF = 2;

    // One configuration write
    typedef struct packed {
        logic                  vld;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Blocks caused by one input byte, in emission order:
    // idle blocks, then an optional start or data block, then an optional terminate
    typedef struct packed {
        logic [IDLE_CNT_W-1:0] idle_cnt;
        logic                  mid_vld;
        logic [SYNC_W-1:0]     mid_sync;
        logic [BLOCK_W-1:0]    mid_data;
        logic                  term_vld;
        logic [BLOCK_W-1:0]    term_data;
    } cmd_t;

    // Queue status toward front and back
    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

    // Back-end status
    typedef struct packed {
        logic busy;
        logic emit;
    } bk_stat_t;

    // Terminate block type for a tail of 0..7 bytes
    function automatic logic [7:0] term_type(input logic [HELD_W-1:0] tail);
        logic [7:0] t;
        case (tail)
            3'd0:    t = 8'h87;
            3'd1:    t = 8'h99;
            3'd2:    t = 8'haa;
            3'd3:    t = 8'hb4;
            3'd4:    t = 8'hcc;
            3'd5:    t = 8'hd2;
            3'd6:    t = 8'he1;
            default: t = 8'hff;
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/pcs_frm_front.sv
// Front end: accepts frame bytes, tracks gap and block assembly, and builds
// one block command per byte. Depends on pcs_frm_pkg.
module pcs_frm_front import pcs_frm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BYTE_W-1:0]  s_frame_byte,
    input  logic               s_last_byte,
    input  cfg_wr_t            cfg,
    input  q_stat_t            q_stat,
    output logic               push,
    output cmd_t               push_cmd
);

    logic [7:0]         gap_eff_reg;
    logic [7:0]         gap_left_reg;
    logic [BLOCK_W-1:0] word_reg;
    logic [HELD_W-1:0]  held_reg;
    logic               in_frame_reg;
    logic               short_reg;
    logic               sent_reg;

    logic [7:0]         gap_left_next;
    logic [BLOCK_W-1:0] word_next;
    logic [HELD_W-1:0]  held_next;
    logic               in_frame_next;
    logic               short_next;
    logic               sent_next;

    logic               acc;
    logic               gap_ge5;
    logic [HELD_W:0]    held_inc;
    logic [HELD_W:0]    need;
    logic [BLOCK_W-1:0] start_blk;
    logic [7:0]         cfg_gap_eff;

    assign s_ready = !q_stat.full;
    assign acc     = s_valid && s_ready;
    assign gap_ge5 = (gap_left_reg[2:0] >= 3'd5);

    assign cfg_gap_eff = (cfg.data[7:0] < GAP_MIN) ? GAP_MIN : cfg.data[7:0];

    // Classify the byte and build its block command
    always_comb begin
        gap_left_next      = gap_left_reg;
        word_next          = word_reg;
        held_next          = held_reg;
        in_frame_next      = in_frame_reg;
        short_next         = short_reg;
        sent_next          = sent_reg;
        push_cmd.idle_cnt  = '0;
        push_cmd.mid_vld   = 1'b0;
        push_cmd.mid_sync  = SYNC_CTRL;
        push_cmd.term_vld  = 1'b0;
        push_cmd.term_data = '0;

        // Frame start: drain the gap as idle blocks and pick the start type
        if (!in_frame_reg) begin
            push_cmd.idle_cnt = {1'b0, gap_left_reg[7:3]} + {{(IDLE_CNT_W-1){1'b0}}, gap_ge5};
            short_next        = (gap_left_reg[2:0] != 3'd0) && !gap_ge5;
            gap_left_next     = '0;
            in_frame_next     = 1'b1;
            sent_next         = 1'b0;
            word_next         = '0;
            held_next         = '0;
        end

        // Place the byte into its lane
        word_next = word_next | (BLOCK_W'(s_frame_byte) << {held_next, 3'b000});
        held_inc  = {1'b0, held_next} + 4'd1;
        need      = short_next ? 4'd3 : 4'd7;

        start_blk = short_next ? {word_next[23:0], 32'd0, TYPE_START_SHORT}
                               : {word_next[55:0], TYPE_START_LONG};
        push_cmd.mid_data = start_blk;

        // Start block once its lanes are full, data block every eight bytes
        if (!sent_next) begin
            if (held_inc >= need) begin
                push_cmd.mid_vld = 1'b1;
                word_next        = '0;
                held_inc         = '0;
                sent_next        = 1'b1;
            end
        end else if (held_inc[HELD_W]) begin
            push_cmd.mid_vld  = 1'b1;
            push_cmd.mid_sync = SYNC_DATA;
            push_cmd.mid_data = word_next;
            word_next         = '0;
            held_inc          = '0;
        end
        held_next = held_inc[HELD_W-1:0];

        // Frame end: flush an unfinished start block, then terminate
        if (s_last_byte) begin
            if (!sent_next) begin
                push_cmd.mid_vld = 1'b1;
                word_next        = '0;
                held_next        = '0;
            end
            push_cmd.term_vld  = 1'b1;
            push_cmd.term_data = {word_next[55:0], term_type(held_next)};
            gap_left_next      = gap_eff_reg - 8'd8 + {5'd0, held_next};
            word_next          = '0;
            held_next          = '0;
            in_frame_next      = 1'b0;
            sent_next          = 1'b0;
        end
    end

    assign push = acc && ((push_cmd.idle_cnt != '0) || push_cmd.mid_vld || push_cmd.term_vld);

    // Advance front state on each input transfer; take gap writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_eff_reg  <= GAP_RESET;
            gap_left_reg <= GAP_RESET;
            word_reg     <= '0;
            held_reg     <= '0;
            in_frame_reg <= 1'b0;
            short_reg    <= 1'b0;
            sent_reg     <= 1'b0;
        end else begin
            if (cfg.vld && cfg.idx == CFG_GAP_BYTES) begin
                gap_eff_reg <= cfg_gap_eff;
                if (!in_frame_reg) begin
                    gap_left_reg <= cfg_gap_eff;
                end
            end else if (acc) begin
                gap_left_reg <= gap_left_next;
            end
            if (acc) begin
                word_reg     <= word_next;
                held_reg     <= held_next;
                in_frame_reg <= in_frame_next;
                short_reg    <= short_next;
                sent_reg     <= sent_next;
            end
        end
    end

endmodule

FILE: rtl/pcs_frm_queue.sv
// Short command queue between the front and back ends.
// Depends on pcs_frm_pkg for the command type.
module pcs_frm_queue import pcs_frm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head_cmd,
    output q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.avail = (count_reg != '0);
    assign head_cmd     = slot_reg[rd_ptr_reg];

    // Store a pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/pcs_frm_back.sv
// Back end: expands block commands into 66-bit blocks, scrambles them and
// holds each in the output register. Depends on pcs_frm_pkg.
module pcs_frm_back import pcs_frm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_wr_t            cfg,
    input  cmd_t               head_cmd,
    input  q_stat_t            q_stat,
    output logic               pop,
    output bk_stat_t           bk_stat,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SYNC_W-1:0]  m_sync_hdr,
    output logic [BLOCK_W-1:0] m_coded_block,
    output logic               m_last_of_run
);

    logic                  active_reg;
    logic [IDLE_CNT_W-1:0] idle_left_reg;
    logic                  mid_pend_reg;
    logic [SYNC_W-1:0]     mid_sync_reg;
    logic [BLOCK_W-1:0]    mid_data_reg;
    logic                  term_pend_reg;
    logic [BLOCK_W-1:0]    term_data_reg;
    logic [SCR_W-1:0]      scram_reg;
    logic [SCR_W-1:0]      scram_next;
    logic                  m_valid_reg;
    logic [SYNC_W-1:0]     m_sync_reg;
    logic [BLOCK_W-1:0]    m_block_reg;
    logic                  m_last_reg;

    logic                  slot_free;
    logic                  emit;
    logic                  sel_idle;
    logic                  sel_mid;
    logic                  blk_last;
    logic [SYNC_W-1:0]     blk_sync;
    logic [BLOCK_W-1:0]    blk_data;
    logic [BLOCK_W-1:0]    scr_out;

    assign slot_free = !m_valid_reg || m_ready;
    assign emit      = active_reg && slot_free;
    assign pop       = !active_reg && q_stat.avail;

    assign bk_stat.busy = active_reg;
    assign bk_stat.emit = emit;

    // Pick the next block of the current command
    always_comb begin
        sel_idle = (idle_left_reg != '0);
        sel_mid  = !sel_idle && mid_pend_reg;
        if (sel_idle) begin
            blk_sync = SYNC_CTRL;
            blk_data = {56'd0, TYPE_IDLE};
            blk_last = (idle_left_reg == IDLE_CNT_W'(1)) && !mid_pend_reg && !term_pend_reg;
        end else if (sel_mid) begin
            blk_sync = mid_sync_reg;
            blk_data = mid_data_reg;
            blk_last = !term_pend_reg;
        end else begin
            blk_sync = SYNC_CTRL;
            blk_data = term_data_reg;
            blk_last = 1'b1;
        end
    end

    // Scramble 64 bits in parallel: out[i] = in[i] ^ out[i-39] ^ out[i-58],
    // where negative positions reach back into the scrambler history
    always_comb begin
        for (int i = 0; i < 39; i++) begin
            scr_out[i] = blk_data[i] ^ scram_reg[38 - i] ^ scram_reg[57 - i];
        end
        for (int i = 39; i < 58; i++) begin
            scr_out[i] = blk_data[i] ^ scr_out[i - 39] ^ scram_reg[57 - i];
        end
        for (int i = 58; i < BLOCK_W; i++) begin
            scr_out[i] = blk_data[i] ^ scr_out[i - 39] ^ scr_out[i - 58];
        end
        for (int j = 0; j < SCR_W; j++) begin
            scram_next[j] = scr_out[BLOCK_W - 1 - j];
        end
    end

    // Load commands and walk through their blocks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            idle_left_reg <= '0;
            mid_pend_reg  <= 1'b0;
            term_pend_reg <= 1'b0;
            scram_reg     <= SEED_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                active_reg    <= 1'b1;
                idle_left_reg <= head_cmd.idle_cnt;
                mid_pend_reg  <= head_cmd.mid_vld;
                term_pend_reg <= head_cmd.term_vld;
            end else if (emit) begin
                if (sel_idle) begin
                    idle_left_reg <= idle_left_reg - 1'b1;
                end else if (sel_mid) begin
                    mid_pend_reg <= 1'b0;
                end else begin
                    term_pend_reg <= 1'b0;
                end
                if (blk_last) begin
                    active_reg <= 1'b0;
                end
            end

            if (cfg.vld && cfg.idx == CFG_SCR_SEED) begin
                scram_reg <= cfg.data[SCR_W-1:0];
            end else if (emit) begin
                scram_reg <= scram_next;
            end

            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Command payload and output block
    always_ff @(posedge aclk) begin
        if (pop) begin
            mid_sync_reg  <= head_cmd.mid_sync;
            mid_data_reg  <= head_cmd.mid_data;
            term_data_reg <= head_cmd.term_data;
        end
        if (emit) begin
            m_sync_reg  <= blk_sync;
            m_block_reg <= scr_out;
            m_last_reg  <= blk_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sync_hdr    = m_sync_reg;
    assign m_coded_block = m_block_reg;
    assign m_last_of_run = m_last_reg;

endmodule

FILE: rtl/pcs_64b66b_frame_encoder.sv
// 64b/66b frame encoder top level: front end, command queue and back end.
// Depends on pcs_frm_pkg, pcs_frm_front, pcs_frm_queue and pcs_frm_back.
//
// Takes one Ethernet frame byte per transfer and sends scrambled 64b/66b
// blocks (sync header 1 for control, 2 for data). The front end accepts a
// byte every cycle while the command queue has room; the back end loads a byte's
// command, then moves one block per cycle into the output register while it is
// free, loading no new command before the last block, so the sustained rate
// is set by the back end's single block-per-cycle scrambler. A frame's first
// byte drains the whole interpacket gap as idle blocks, up to 32 of them; a
// one-byte frame adds its start and terminate blocks, 34 blocks in all. The
// configuration port never stalls; write gap_bytes (index 0) and
// scrambler_seed (index 1) only while the encoder is idle.
module pcs_64b66b_frame_encoder import pcs_frm_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_frame_byte,
    input  logic                  s_last_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SYNC_W-1:0]     m_sync_hdr,
    output logic [BLOCK_W-1:0]    m_coded_block,
    output logic                  m_last_of_run,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_wr_t  cfg;
    q_stat_t  q_stat;
    bk_stat_t bk_stat;
    cmd_t     push_cmd;
    cmd_t     head_cmd;
    logic     push;
    logic     pop;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg.vld   = cfg_valid;
    assign cfg.idx   = cfg_index;
    assign cfg.data  = cfg_data;

    pcs_frm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_frame_byte (s_frame_byte),
        .s_last_byte  (s_last_byte),
        .cfg          (cfg),
        .q_stat       (q_stat),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    pcs_frm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    pcs_frm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .head_cmd      (head_cmd),
        .q_stat        (q_stat),
        .pop           (pop),
        .bk_stat       (bk_stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sync_hdr    (m_sync_hdr),
        .m_coded_block (m_coded_block),
        .m_last_of_run (m_last_of_run)
    );

    // Every block carries a legal sync header
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sync_hdr == SYNC_CTRL || m_sync_hdr == SYNC_DATA))
        else $error("illegal sync header on output block");

    // A transfer that is not the end of a run leaves more blocks pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> (m_valid || bk_stat.busy))
        else $error("run ended without a last block");

    // Reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // The back end only loads a command when the queue holds one and it is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (q_stat.avail && !bk_stat.busy && !bk_stat.emit))
        else $error("command load while busy or queue empty");

endmodule

FILE: sim/pcs_frm_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard for the 64b/66b frame encoder: predicts the scrambled block stream
// from accepted frame bytes and register writes and checks every output transfer.
// Depends on pcs_frm_pkg.
module pcs_frm_scoreboard import pcs_frm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_frame_byte,
    input  logic                  s_last_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [SYNC_W-1:0]     m_sync_hdr,
    input  logic [BLOCK_W-1:0]    m_coded_block,
    input  logic                  m_last_of_run,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_cnt,
    output int                    blocks_pending,
    output int                    blocks_checked
);

    typedef struct packed {
        logic [SYNC_W-1:0]  sync;
        logic [BLOCK_W-1:0] payload;
        logic               last;
    } coded_blk_t;

    // Terminate type codes, one byte per tail length, tail 0 in the low byte
    localparam logic [63:0]        TERM_CODES = 64'hffe1d2ccb4aa9987;
    localparam logic [BLOCK_W-1:0] IDLE_BLOCK = {56'd0, TYPE_IDLE};

    // Encoder state as seen from the ports
    logic [7:0]         gap_cfg;
    logic [SCR_W-1:0]   scr_state;
    logic [7:0]         gap_left;
    logic [BLOCK_W-1:0] lane_word;
    int                 lane_cnt;
    logic               in_frame;
    logic               short_start;
    logic               start_done;
    coded_blk_t         expected_q[$];
    int                 err_cnt = 0;
    int                 checked_cnt = 0;

    function automatic logic [7:0] gap_eff();
        return (gap_cfg < GAP_MIN) ? GAP_MIN : gap_cfg;
    endfunction

    // Scramble one payload LSB first and advance the scrambler
    function automatic logic [BLOCK_W-1:0] scramble(input logic [BLOCK_W-1:0] din);
        logic [BLOCK_W-1:0] dout;
        logic               bit_out;
        dout = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            bit_out   = din[i] ^ scr_state[38] ^ scr_state[57];
            scr_state = {scr_state[SCR_W-2:0], bit_out};
            dout[i]   = bit_out;
        end
        return dout;
    endfunction

    task automatic push_block(input logic [SYNC_W-1:0] sync,
                              input logic [BLOCK_W-1:0] payload);
        coded_blk_t blk;
        blk.sync    = sync;
        blk.payload = scramble(payload);
        blk.last    = 1'b0;
        expected_q.push_back(blk);
    endtask

    // Close the start block with whatever lanes are filled so far
    task automatic push_start();
        if (short_start)
            push_block(SYNC_CTRL, (lane_word << 40) | {56'd0, TYPE_START_SHORT});
        else
            push_block(SYNC_CTRL, (lane_word << 8) | {56'd0, TYPE_START_LONG});
        lane_word  = '0;
        lane_cnt   = 0;
        start_done = 1'b1;
    endtask

    // Expected blocks for one accepted frame byte
    task automatic encode_byte(input logic [7:0] fbyte, input logic last);
        int         gap_rem;
        int         run_start;
        int         need;
        logic [7:0] used_n;
        coded_blk_t blk;
        run_start = expected_q.size();
        if (!in_frame) begin
            // Drain the idle gap before the frame opens
            gap_rem = int'(gap_left);
            while (gap_rem >= 8) begin
                push_block(SYNC_CTRL, IDLE_BLOCK);
                gap_rem -= 8;
            end
            short_start = (gap_rem >= 1 && gap_rem <= 4);
            if (!short_start && gap_rem != 0)
                push_block(SYNC_CTRL, IDLE_BLOCK);
            gap_left   = '0;
            in_frame   = 1'b1;
            start_done = 1'b0;
            lane_word  = '0;
            lane_cnt   = 0;
        end

        lane_word[lane_cnt*8 +: 8] = fbyte;
        lane_cnt++;
        if (!start_done) begin
            need = short_start ? 3 : 7;
            if (lane_cnt >= need)
                push_start();
        end else if (lane_cnt == 8) begin
            push_block(SYNC_DATA, lane_word);
            lane_word = '0;
            lane_cnt  = 0;
        end

        // Close the frame: flush an unfinished start, then the terminate
        if (last) begin
            if (!start_done)
                push_start();
            push_block(SYNC_CTRL, (lane_word << 8) | {56'd0, TERM_CODES[lane_cnt*8 +: 8]});
            used_n     = 8'(8 - lane_cnt);
            gap_left   = gap_eff() - used_n;
            lane_word  = '0;
            lane_cnt   = 0;
            in_frame   = 1'b0;
            start_done = 1'b0;
        end

        // Flag the final block of this byte's run
        if (expected_q.size() > run_start) begin
            blk      = expected_q.pop_back();
            blk.last = 1'b1;
            expected_q.push_back(blk);
        end
    endtask

    always @(posedge aclk) begin : track
        coded_blk_t exp_blk;
        if (!aresetn) begin
            gap_cfg     = GAP_RESET;
            scr_state   = SEED_RESET;
            gap_left    = GAP_RESET;
            lane_word   = '0;
            lane_cnt    = 0;
            in_frame    = 1'b0;
            short_start = 1'b0;
            start_done  = 1'b0;
            expected_q.delete();
        end else begin
            // Register writes take effect at the transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GAP_BYTES: begin
                        gap_cfg = cfg_data[7:0];
                        if (!in_frame)
                            gap_left = gap_eff();
                    end
                    CFG_SCR_SEED: scr_state = cfg_data[SCR_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                encode_byte(s_frame_byte, s_last_byte);

            // Compare each output transfer against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected block: m_sync_hdr %0d coded_block %h last_of_run %0d",
                           m_sync_hdr, m_coded_block, m_last_of_run);
                    err_cnt++;
                end else begin
                    exp_blk = expected_q.pop_front();
                    checked_cnt++;
                    if (m_sync_hdr !== exp_blk.sync) begin
                        $error("m_sync_hdr: expected %0d, actual %0d",
                               exp_blk.sync, m_sync_hdr);
                        err_cnt++;
                    end
                    if (m_coded_block !== exp_blk.payload) begin
                        $error("coded_block: expected %h, actual %h",
                               exp_blk.payload, m_coded_block);
                        err_cnt++;
                    end
                    if (m_last_of_run !== exp_blk.last) begin
                        $error("last_of_run: expected %0d, actual %0d",
                               exp_blk.last, m_last_of_run);
                        err_cnt++;
                    end
                end
            end
        end
        mismatch_cnt   <= err_cnt;
        blocks_pending <= expected_q.size();
        blocks_checked <= checked_cnt;
    end

endmodule

FILE: sim/tb_pcs_64b66b_frame_encoder.sv
`timescale 1ns / 100ps
// Testbench top for pcs_64b66b_frame_encoder: drives frame bytes and register
// writes, throttles the block output and reports the verdict.
// Depends on pcs_frm_pkg, the encoder RTL and pcs_frm_scoreboard.
module tb_pcs_64b66b_frame_encoder import pcs_frm_pkg::*; ();

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 30;

    // Byte fill patterns for frames
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;
    localparam int FILL_ALT    = 3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_frame_byte = '0;
    logic                  s_last_byte = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [SYNC_W-1:0]     m_sync_hdr;
    logic [BLOCK_W-1:0]    m_coded_block;
    logic                  m_last_of_run;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_GAP_BYTES;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   tx_idle_pct = 0;
    int   rx_stall_pct = 0;
    logic rx_blocked = 1'b0;
    int   mismatch_cnt;
    int   blocks_pending;
    int   blocks_checked;
    int   bytes_sent = 0;
    int   frames_sent = 0;
    int   short_frames = 0;
    int   quiet_cycles = 0;

    always #2 aclk = ~aclk;

    pcs_64b66b_frame_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_frame_byte  (s_frame_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sync_hdr    (m_sync_hdr),
        .m_coded_block (m_coded_block),
        .m_last_of_run (m_last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pcs_frm_scoreboard u_score (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frame_byte   (s_frame_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sync_hdr     (m_sync_hdr),
        .m_coded_block  (m_coded_block),
        .m_last_of_run  (m_last_of_run),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_cnt   (mismatch_cnt),
        .blocks_pending (blocks_pending),
        .blocks_checked (blocks_checked)
    );

    // Output side: random backpressure, forced low during the fill test
    always @(posedge aclk)
        m_ready <= !rx_blocked && ($urandom_range(99) >= rx_stall_pct);

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one byte, idling first at random, and hold it until the transfer
    task automatic send_byte(input logic [7:0] fbyte, input logic last);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid      <= 1'b1;
        s_frame_byte <= fbyte;
        s_last_byte  <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_frame(input int len, input int fill);
        logic [7:0] fbyte;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: fbyte = 8'h00;
                FILL_ONES: fbyte = 8'hff;
                FILL_ALT:  fbyte = (i % 2) ? 8'hff : 8'h00;
                default:   fbyte = 8'($urandom_range(255));
            endcase
            send_byte(fbyte, i == len - 1);
        end
        frames_sent++;
        if (len < 8)
            short_frames++;
    endtask

    // Mostly well-formed frames, some that end before the start block fills
    task automatic send_random_frames(input int n_bytes);
        int first_byte;
        int len;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < n_bytes) begin
            if ($urandom_range(99) < 15)
                len = $urandom_range(1, 7);
            else if ($urandom_range(99) < 80)
                len = $urandom_range(8, 24);
            else
                len = $urandom_range(25, 64);
            send_frame(len, FILL_RANDOM);
        end
    endtask

    // Drop valid, wait for every expected block, then let the back end settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (blocks_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both registers back to back on the configuration channel
    task automatic configure(input logic [7:0] gap, input logic [SCR_W-1:0] seed);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_GAP_BYTES;
        cfg_data  <= {{(CFG_DATA_W-8){1'b0}}, gap};
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_SCR_SEED;
        cfg_data  <= seed;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int               pick;
        logic [7:0]       gap;
        logic [63:0]      r64;
        logic [SCR_W-1:0] seed;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: frames that end before the start block is full
        send_frame(1, FILL_ONES);
        send_frame(2, FILL_ZERO);
        wait_idle();
        // Widest gap with an all-zero scrambler
        configure(8'd255, '0);
        send_frame(9, FILL_ALT);
        wait_idle();
        // Gap below the minimum behaves as the minimum
        configure(8'd5, SEED_RESET);
        send_frame(13, FILL_RANDOM);
        wait_idle();

        // Random phases with different idling on each side
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 72; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 72; end
                default: begin tx_idle_pct = 8;  rx_stall_pct = 8;  end
            endcase
            pick = $urandom_range(3);
            case (pick)
                0:       gap = GAP_MIN;
                1:       gap = 8'd255;
                2:       gap = 8'($urandom_range(12, 255));
                default: gap = 8'($urandom_range(0, 11));
            endcase
            r64  = {$urandom, $urandom};
            pick = $urandom_range(2);
            seed = (pick == 0) ? '0 : (pick == 1) ? SEED_RESET : r64[SCR_W-1:0];
            configure(gap, seed);
            send_random_frames(PHASE_BYTES);
            wait_idle();
        end

        // Fill test: hold the output off while bytes keep coming
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        fork
            begin
                rx_blocked <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_blocked <= 1'b0;
            end
            send_random_frames(25);
        join
        wait_idle();

        $display("Covered %0d frames (%0d under 8 bytes), %0d bytes, %0d blocks checked.",
                 frames_sent, short_frames, bytes_sent, blocks_checked);
        $display("Gaps at minimum, below it and at 255; zero, all-ones and random seeds; %s",
                 "idle, throttled and fill phases.");
        if (mismatch_cnt == 0 && blocks_pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
